@@ design/srsw_pkg.sv @@
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int MAX_RESULTS         = 16;
  localparam int DEF_WINDOW_SLOTS    = 16;
  localparam int DEF_TIMER_BITS      = 16;
  localparam int CNT_BITS            = $clog2(MAX_RESULTS + 1);

  localparam logic [4:0]  WINDOW_RESET  = 5'd16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_GRANTED    = 3'd0,
    KIND_REFUSED    = 3'd1,
    KIND_ACK_OK     = 3'd2,
    KIND_ACK_IGNORE = 3'd3,
    KIND_RETRANSMIT = 3'd4
  } kind_t;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_WINDOW  = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLIDE,
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Strobes from the controller to one slot cell.
  typedef struct packed {
    logic tick;
    logic send;
    logic ack;
    logic slide;
    logic renew;
  } slot_ctrl_t;

endpackage

@@ design/srsw_slot.sv @@
// ----------------------------------------------------------------------------
// srsw_slot
// State of one window slot: flags, retransmit countdown and send order.
// ----------------------------------------------------------------------------
module srsw_slot
  import srsw_pkg::*;
#(
  parameter int TIMER_BITS = DEF_TIMER_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  slot_ctrl_t            ctrl,
  input  logic [TIMER_BITS-1:0] load_value,
  input  logic [31:0]           order_counter,
  output logic                  outstanding,
  output logic                  acked,
  output logic                  expired,
  output logic [31:0]           age
);

  logic [TIMER_BITS-1:0] countdown;
  logic [31:0]           send_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= 1'b0;
      acked       <= 1'b0;
    end else if (ctrl.send) begin
      outstanding <= 1'b1;
      acked       <= 1'b0;
    end else if (ctrl.ack) begin
      outstanding <= 1'b0;
      acked       <= 1'b1;
    end else if (ctrl.slide) begin
      acked       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.send || ctrl.renew) begin
      countdown  <= load_value;
      send_order <= order_counter;
    end else if (ctrl.tick && outstanding && countdown != '0) begin
      countdown  <= countdown - 1'b1;
    end
  end

  assign expired = outstanding && (countdown == '0);
  assign age     = order_counter - send_order;

endmodule

@@ design/srsw_sort_cell.sv @@
// ----------------------------------------------------------------------------
// srsw_sort_cell
// One cell of the sorted retransmit chain, oldest entry at the head.
// ----------------------------------------------------------------------------
module srsw_sort_cell
  import srsw_pkg::*;
#(
  parameter int IDX_BITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                ins,
  input  logic                pop,
  input  logic [31:0]         new_age,
  input  logic [IDX_BITS-1:0] new_idx,
  input  logic                prev_keep,
  input  logic                prev_valid,
  input  logic [31:0]         prev_age,
  input  logic [IDX_BITS-1:0] prev_idx,
  input  logic                nxt_valid,
  input  logic [31:0]         nxt_age,
  input  logic [IDX_BITS-1:0] nxt_idx,
  output logic                keep,
  output logic                valid,
  output logic [31:0]         age,
  output logic [IDX_BITS-1:0] idx
);

  // An entry of equal age stays ahead, so equal ages keep slot order.
  assign keep = valid && (age >= new_age);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (ins && !keep) begin
      valid <= prev_keep ? 1'b1 : prev_valid;
    end else if (pop) begin
      valid <= nxt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ins && !keep) begin
      age <= prev_keep ? new_age : prev_age;
      idx <= prev_keep ? new_idx : prev_idx;
    end else if (pop) begin
      age <= nxt_age;
      idx <= nxt_idx;
    end
  end

endmodule

@@ design/selective_repeat_sender_window_core.sv @@
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_core
// Sender window of selective-repeat ARQ: grants, acks and retransmits.
// ----------------------------------------------------------------------------
// Input words arrive on the s_ side: s_tuser carries the operation (send
// request, ack, tick) and s_tdata the ack number and its checksum flag. Result
// words leave on the m_ side, with m_tlast on the final result of each input.
// A send request gives one result in the cycle after it is accepted. An ack
// gives one result after the base has slid past the acknowledged numbers at
// its front. A tick runs an expiry scan over the slot cells in order into a
// sorting chain, then emits one retransmit per cycle while the receiver takes
// them, oldest send first. A quiet tick gives no result. Items are taken one
// at a time; the input is ready again once the previous item is finished and
// the output register is free or being drained. When the receiver stalls, the
// output register holds its word and the block waits. Reset (synchronous,
// active high) clears the base, the next number, the send order counter and
// all slot flags, and loads the default window of 16 and timeout of 1000
// ticks. The user must write the window at APB address 0 and the timeout at
// address 4 only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_core
  import srsw_pkg::*;
#(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS,
  parameter int TIMER_BITS   = DEF_TIMER_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] ack_number, [32] ack_checksum_ok
  input  logic [1:0]  s_tuser,   // [1:0] operation
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] seq_number, [63:32] window_base
  output logic [2:0]  m_tuser,   // [2:0] result_kind
  output logic        m_tlast    // last
);

  localparam int SW    = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int WCAP  = (WINDOW_SLOTS < MAX_RESULTS) ? WINDOW_SLOTS : MAX_RESULTS;
  localparam logic [SW:0] NS = (SW + 1)'(WINDOW_SLOTS);
  localparam logic [SW:0] NS_LAST = (SW + 1)'(WINDOW_SLOTS - 1);
  localparam logic [4:0]  WCAP5 = 5'(WCAP);
  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_RESULTS);

  // Configuration registers.
  logic [4:0]  window_size;
  logic [15:0] timeout_ticks;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_t'(paddr[2]))
        REG_WINDOW:  window_size   <= pwdata[4:0];
        REG_TIMEOUT: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_t'(paddr[2]))
      REG_WINDOW:  prdata = {27'd0, window_size};
      REG_TIMEOUT: prdata = {16'd0, timeout_ticks};
      default:     prdata = '0;
    endcase
  end

  // Effective window and countdown load value.
  logic [4:0]            win;
  logic [32:0]           to_ext;
  logic [32:0]           cap_ext;
  logic [TIMER_BITS-1:0] load_value;

  assign win        = (window_size > WCAP5) ? WCAP5 : window_size;
  assign to_ext     = {17'd0, timeout_ticks};
  assign cap_ext    = (33'd1 << TIMER_BITS) - 33'd1;
  assign load_value = (to_ext > cap_ext) ? cap_ext[TIMER_BITS-1:0]
                                         : to_ext[TIMER_BITS-1:0];

  // Window state.
  logic [31:0]   base_seq;
  logic [31:0]   next_seq;
  logic [31:0]   order_counter;
  logic [SW-1:0] base_slot;
  logic [SW-1:0] next_slot;
  state_t        state, state_next;

  // Input decode.
  logic        in_acc;
  op_t         op;
  logic [31:0] ack_number;
  logic        ack_ok_in;

  assign s_tready   = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign in_acc     = s_tvalid && s_tready;
  assign op         = op_t'(s_tuser);
  assign ack_number = s_tdata[31:0];
  assign ack_ok_in  = s_tdata[32];

  logic [32:0] win_end;
  logic        send_grant;
  logic [31:0] ack_off;
  logic [SW:0] ack_sum;
  logic [SW-1:0] ack_slot;
  logic        ack_in_win;
  logic        ack_hit;

  logic [WINDOW_SLOTS-1:0] slot_out;
  logic [WINDOW_SLOTS-1:0] slot_acked;
  logic [WINDOW_SLOTS-1:0] slot_exp;
  logic [31:0]             slot_age [WINDOW_SLOTS];

  assign win_end    = {1'b0, base_seq} + {28'd0, win};
  assign send_grant = ({1'b0, next_seq} < win_end) && (next_seq != 32'hFFFF_FFFF);
  assign ack_in_win = ack_ok_in && (ack_number >= base_seq)
                   && ({1'b0, ack_number} < win_end) && (ack_number < next_seq);
  assign ack_off    = ack_number - base_seq;
  assign ack_sum    = {1'b0, base_slot} + {1'b0, ack_off[SW-1:0]};
  assign ack_slot   = (ack_sum >= NS) ? SW'(ack_sum - NS) : ack_sum[SW-1:0];
  assign ack_hit    = ack_in_win && slot_out[ack_slot];

  // Pending ack result, emitted after the base slide.
  kind_t       ack_kind;
  logic [31:0] ack_seq;

  always_ff @(posedge clk) begin
    if (in_acc && op == OP_ACK) begin
      ack_kind <= ack_hit ? KIND_ACK_OK : KIND_ACK_IGNORE;
      ack_seq  <= ack_number;
    end
  end

  // Expiry scan: a shift line loaded from every slot after the tick.
  logic [WINDOW_SLOTS-1:0] scan_exp;
  logic [31:0]             scan_age [WINDOW_SLOTS];
  logic [SW:0]             scan_pos;
  logic [CNT_BITS-1:0]     count;

  // Sorting chain.
  logic                chain_valid [MAX_RESULTS];
  logic [31:0]         chain_age   [MAX_RESULTS];
  logic [SW-1:0]       chain_idx   [MAX_RESULTS];
  logic                chain_keep  [MAX_RESULTS];

  // Controller strobes.
  logic out_free;
  logic slide_step;
  logic emit_ack;
  logic emit_rtx;
  logic scan_ins;
  logic chain_clear;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && op == OP_ACK)  state_next = ST_SLIDE;
        if (in_acc && op == OP_TICK) state_next = ST_LOAD;
      end
      ST_SLIDE: if (!slide_step && out_free) state_next = ST_IDLE;
      ST_LOAD:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_pos == NS_LAST) begin
          state_next = (count == '0 && !scan_ins) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT:  if (out_free && count == CNT_BITS'(1)) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    slide_step  = 1'b0;
    emit_ack    = 1'b0;
    emit_rtx    = 1'b0;
    scan_ins    = 1'b0;
    chain_clear = 1'b0;
    unique case (state)
      ST_SLIDE: begin
        slide_step = (base_seq < next_seq) && slot_acked[base_slot];
        emit_ack   = !slide_step && out_free;
      end
      ST_LOAD:  chain_clear = 1'b1;
      ST_SCAN:  scan_ins = scan_exp[0] && (count < CNT_MAX);
      ST_EMIT:  emit_rtx = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Retransmitted number from the head slot.
  logic [SW:0]   rtx_d;
  logic [SW-1:0] rtx_off;
  logic [31:0]   rtx_seq;

  assign rtx_d   = {1'b0, chain_idx[0]} + NS - {1'b0, base_slot};
  assign rtx_off = (rtx_d >= NS) ? SW'(rtx_d - NS) : rtx_d[SW-1:0];
  assign rtx_seq = base_seq + 32'(rtx_off);

  // Window pointers and counters.
  logic do_send;
  assign do_send = in_acc && op == OP_SEND && send_grant;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq      <= '0;
      next_seq      <= '0;
      base_slot     <= '0;
      next_slot     <= '0;
      order_counter <= '0;
    end else begin
      if (do_send) begin
        next_seq  <= next_seq + 32'd1;
        next_slot <= ({1'b0, next_slot} == NS_LAST) ? '0 : next_slot + 1'b1;
      end
      if (slide_step) begin
        base_seq  <= base_seq + 32'd1;
        base_slot <= ({1'b0, base_slot} == NS_LAST) ? '0 : base_slot + 1'b1;
      end
      if (do_send || emit_rtx) order_counter <= order_counter + 32'd1;
    end
  end

  // Scan line and chain fill count.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      scan_exp <= slot_exp;
      for (int i = 0; i < WINDOW_SLOTS; i++) scan_age[i] <= slot_age[i];
    end else if (state == ST_SCAN) begin
      scan_exp <= scan_exp >> 1;
      for (int i = 0; i < WINDOW_SLOTS - 1; i++) scan_age[i] <= scan_age[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos <= '0;
      count    <= '0;
    end else begin
      if (state == ST_LOAD) begin
        scan_pos <= '0;
        count    <= '0;
      end else if (state == ST_SCAN) begin
        scan_pos <= scan_pos + 1'b1;
        if (scan_ins) count <= count + 1'b1;
      end else if (emit_rtx) begin
        count <= count - 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((in_acc && op == OP_SEND) || emit_ack || emit_rtx) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && op == OP_SEND) begin
      m_tuser <= send_grant ? KIND_GRANTED : KIND_REFUSED;
      m_tdata <= {base_seq, next_seq};
      m_tlast <= 1'b1;
    end else if (emit_ack) begin
      m_tuser <= ack_kind;
      m_tdata <= {base_seq, ack_seq};
      m_tlast <= 1'b1;
    end else if (emit_rtx) begin
      m_tuser <= KIND_RETRANSMIT;
      m_tdata <= {base_seq, rtx_seq};
      m_tlast <= (count == CNT_BITS'(1));
    end
  end

  // Slot cells.
  for (genvar g = 0; g < WINDOW_SLOTS; g++) begin : g_slot
    slot_ctrl_t ctrl;
    assign ctrl.tick  = in_acc && op == OP_TICK;
    assign ctrl.send  = do_send && next_slot == SW'(g);
    assign ctrl.ack   = in_acc && op == OP_ACK && ack_hit && ack_slot == SW'(g);
    assign ctrl.slide = slide_step && base_slot == SW'(g);
    assign ctrl.renew = emit_rtx && chain_idx[0] == SW'(g);

    srsw_slot #(
      .TIMER_BITS (TIMER_BITS)
    ) u_slot (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .load_value    (load_value),
      .order_counter (order_counter),
      .outstanding   (slot_out[g]),
      .acked         (slot_acked[g]),
      .expired       (slot_exp[g]),
      .age           (slot_age[g])
    );
  end

  // Sorting chain, oldest send at cell 0.
  for (genvar k = 0; k < MAX_RESULTS; k++) begin : g_sort
    logic                pk, pv, nv;
    logic [31:0]         pa, na;
    logic [SW-1:0]       pi, ni;
    if (k == 0) begin : g_head
      assign pk = 1'b1;
      assign pv = 1'b0;
      assign pa = '0;
      assign pi = '0;
    end else begin : g_body
      assign pk = chain_keep[k - 1];
      assign pv = chain_valid[k - 1];
      assign pa = chain_age[k - 1];
      assign pi = chain_idx[k - 1];
    end
    if (k == MAX_RESULTS - 1) begin : g_tail
      assign nv = 1'b0;
      assign na = '0;
      assign ni = '0;
    end else begin : g_mid
      assign nv = chain_valid[k + 1];
      assign na = chain_age[k + 1];
      assign ni = chain_idx[k + 1];
    end

    srsw_sort_cell #(
      .IDX_BITS (SW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .clear      (chain_clear),
      .ins        (scan_ins),
      .pop        (emit_rtx),
      .new_age    (scan_age[0]),
      .new_idx    (scan_pos[SW-1:0]),
      .prev_keep  (pk),
      .prev_valid (pv),
      .prev_age   (pa),
      .prev_idx   (pi),
      .nxt_valid  (nv),
      .nxt_age    (na),
      .nxt_idx    (ni),
      .keep       (chain_keep[k]),
      .valid      (chain_valid[k]),
      .age        (chain_age[k]),
      .idx        (chain_idx[k])
    );
  end

endmodule
